FILE: rtl/core/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and codes for the bounded lifo stack core.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    // command codes carried on the request kind field
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

    // per-cycle control broadcast to every cell of the chain
    typedef struct packed {
        logic push;   // shift main chain towards the bottom, top takes the new word
        logic pop;    // shift main chain towards the top
        logic load;   // copy main chain into the dump chain
        logic shift;  // move dump chain one place towards the top
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/core/bls_cell.sv
// ----------------------------------------------------------------------------
// bls_cell
// One stack slot: a stored word plus a dump copy, both handed to neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_cell
    import bls_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire logic [DATA_W-1:0] i_above,         // word of the cell nearer the top
    input  wire logic [DATA_W-1:0] i_below,         // word of the cell nearer the bottom
    input  wire logic [DATA_W-1:0] i_shadow_below,  // dump copy of the cell below
    output logic      [DATA_W-1:0] o_data,
    output logic      [DATA_W-1:0] o_shadow
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] r_shadow;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_data <= i_above;
        end else if (i_ctrl.pop) begin
            r_data <= i_below;
        end
        if (i_ctrl.load) begin
            r_shadow <= r_data;
        end else if (i_ctrl.shift) begin
            r_shadow <= i_shadow_below;
        end
    end

    assign o_data   = r_data;
    assign o_shadow = r_shadow;

endmodule

`default_nettype wire

FILE: rtl/core/bounded_lifo_stack_core.sv
// ----------------------------------------------------------------------------
// bounded_lifo_stack_core
// Fixed-depth lifo of 32-bit words built as a chain of shifting cells.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata          | tuser        | tlast
//  s_axis   | in  | value [31:0]   | command[1:0] | -
//  m_axis   | out | data  [31:0]   | status [1:0] | last result of the request
//
// push and pop results are registered; a new request is taken every cycle while
// the output register is free or being drained.
// a dump of n entries first copies the chain into the dump cells, then outputs
// n words, one cell shift per word; no request is taken meanwhile.
// synchronous active-low reset empties the stack; stored words are not cleared.
// a stalled output holds its word and blocks new requests.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_lifo_stack_core
    import bls_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  wire logic [CMD_W-1:0]  s_axis_tuser,   // [1:0] command
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [DATA_W-1:0] m_axis_tdata,   // [31:0] data
    output logic      [STAT_W-1:0] m_axis_tuser,   // [1:0] status
    output logic                   m_axis_tlast
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_dump_left;
    logic                r_m_valid;
    logic [DATA_W-1:0]   r_m_data;
    logic [STAT_W-1:0]   r_m_status;
    logic                r_m_last;

    logic                w_out_free;
    logic                w_fire;
    logic                w_full;
    logic                w_empty;
    logic                w_emit;
    t_cell_ctrl          w_ctrl;
    logic [DATA_W-1:0]   w_data   [DEPTH];
    logic [DATA_W-1:0]   w_shadow [DEPTH];

    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_fire        = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(DEPTH));
    assign w_empty       = (r_count == '0);

    always_comb begin
        w_ctrl.push  = w_fire && (s_axis_tuser == CMD_PUSH) && !w_full;
        w_ctrl.pop   = w_fire && (s_axis_tuser == CMD_POP)  && !w_empty;
        w_ctrl.load  = w_fire && (s_axis_tuser == CMD_DUMP) && !w_empty;
        w_ctrl.shift = (r_state == S_DUMP) && w_out_free;
    end

    // a result enters the output register this cycle
    assign w_emit = (w_fire && ((s_axis_tuser == CMD_PUSH) || (s_axis_tuser == CMD_POP) ||
                                ((s_axis_tuser == CMD_DUMP) && w_empty)))
                    || w_ctrl.shift;

    // cell 0 is the top of the stack
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_above;
        logic [DATA_W-1:0] w_below;
        logic [DATA_W-1:0] w_sh_below;

        if (g == 0) begin : g_top
            assign w_above = s_axis_tdata;
        end else begin : g_mid_above
            assign w_above = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_bottom
            assign w_below    = '0;
            assign w_sh_below = '0;
        end else begin : g_mid_below
            assign w_below    = w_data[g+1];
            assign w_sh_below = w_shadow[g+1];
        end

        bls_cell u_cell (
            .i_clk          (i_clk),
            .i_ctrl         (w_ctrl),
            .i_above        (w_above),
            .i_below        (w_below),
            .i_shadow_below (w_sh_below),
            .o_data         (w_data[g]),
            .o_shadow       (w_shadow[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dump_left <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_m_valid <= w_emit || (r_m_valid && !m_axis_tready);
            case (r_state)
                S_IDLE: begin
                    if (w_fire) begin
                        case (s_axis_tuser)
                            CMD_PUSH: begin
                                r_m_data  <= '0;
                                r_m_last  <= 1'b1;
                                if (w_full) begin
                                    r_m_status <= STAT_OVERFLOW;
                                end else begin
                                    r_m_status <= STAT_OK;
                                    r_count    <= r_count + CNT_W'(1);
                                end
                            end
                            CMD_POP: begin
                                r_m_last  <= 1'b1;
                                if (w_empty) begin
                                    r_m_data   <= '0;
                                    r_m_status <= STAT_UNDERFLOW;
                                end else begin
                                    r_m_data   <= w_data[0];
                                    r_m_status <= STAT_OK;
                                    r_count    <= r_count - CNT_W'(1);
                                end
                            end
                            CMD_DUMP: begin
                                if (w_empty) begin
                                    r_m_data   <= '0;
                                    r_m_status <= STAT_UNDERFLOW;
                                    r_m_last   <= 1'b1;
                                end else begin
                                    r_dump_left <= r_count;
                                    r_state     <= S_DUMP;
                                end
                            end
                            default: begin
                                // undefined command, no result
                            end
                        endcase
                    end
                end
                S_DUMP: begin
                    if (w_out_free) begin
                        r_m_data    <= w_shadow[0];
                        r_m_status  <= STAT_OK;
                        r_m_last    <= (r_dump_left == CNT_W'(1));
                        r_dump_left <= r_dump_left - CNT_W'(1);
                        if (r_dump_left == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire
